>>> sv/krp_pkg.sv
// ----------------------------------------------------------------------------
// krp_pkg: shared types and constants for the k-means reassignment pass
// Opcodes, register indexes, controller states and the cell control group.
// ----------------------------------------------------------------------------
package krp_pkg;

  localparam int SUM_BITS      = 40;
  localparam int SDELTA_BITS   = 41;
  localparam int TALLY_BITS    = 24;
  localparam int CLASS_BITS    = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CLASSES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_BANDS   = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD_COUNT = 2'd0,
    OP_LOAD_SUM   = 2'd1,
    OP_POINT      = 2'd2,
    OP_ABORT      = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_PROD,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_X_GO,
    ST_X_WAIT,
    ST_NEXT,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       shift;
    logic       clr;
    logic       wr_count;
    logic       wr_sum;
    logic [2:0] band;
  } cell_ctl_t;

endpackage

>>> sv/krp_cell.sv
// ----------------------------------------------------------------------------
// krp_cell: one class record in the rotating class chain
// Holds count, band sums and pending deltas; takes its neighbor's record on shift.
// ----------------------------------------------------------------------------
module krp_cell #(
  parameter int BANDS      = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  krp_pkg::cell_ctl_t                           ctl,
  input  logic                                         sel,
  input  logic [krp_pkg::SUM_BITS-1:0]                 load_value,
  input  logic [COUNT_BITS-1:0]                        nxt_count,
  input  logic [BANDS-1:0][krp_pkg::SUM_BITS-1:0]      nxt_sum,
  input  logic [COUNT_BITS:0]                          nxt_cd,
  input  logic [BANDS-1:0][krp_pkg::SDELTA_BITS-1:0]   nxt_sd,
  output logic [COUNT_BITS-1:0]                        count,
  output logic [BANDS-1:0][krp_pkg::SUM_BITS-1:0]      sum,
  output logic [COUNT_BITS:0]                          cd,
  output logic [BANDS-1:0][krp_pkg::SDELTA_BITS-1:0]   sd
);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      cd    <= '0;
      sd    <= '0;
    end else if (ctl.shift) begin
      count <= nxt_count;
      sum   <= nxt_sum;
      cd    <= nxt_cd;
      sd    <= nxt_sd;
    end else begin
      if (sel && ctl.wr_count) begin
        count <= load_value[COUNT_BITS-1:0];
      end
      if (sel && ctl.wr_sum) begin
        for (int j = 0; j < BANDS; j++) begin
          if (ctl.band == 3'(j)) begin
            sum[j] <= load_value;
          end
        end
      end
      if (ctl.clr) begin
        cd <= '0;
        sd <= '0;
      end
    end
  end

endmodule

>>> sv/krp_sermul.sv
// ----------------------------------------------------------------------------
// krp_sermul: shift-and-add multiplier
// Consumes one bit of b per cycle; done pulses when the product is ready.
// ----------------------------------------------------------------------------
module krp_sermul #(
  parameter int AW = 40,
  parameter int BW = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] ash;
  logic [BW-1:0]    bsh;
  logic [CW-1:0]    cnt;
  logic             run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      done <= (cnt == CW'(BW - 1));
      run  <= (cnt != CW'(BW - 1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      ash  <= (AW+BW)'(a);
      bsh  <= b;
      cnt  <= '0;
    end else if (run) begin
      if (bsh[0]) begin
        prod <= prod + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
      cnt <= cnt + CW'(1);
    end
  end

endmodule

>>> sv/kmeans_reassign_pass_unit.sv
// ----------------------------------------------------------------------------
// kmeans_reassign_pass_unit: k-means reassignment over a rotating class chain
// Load requests complete when accepted. An abort request goes through the emit state.
// A point request runs the serial multipliers for each active nonempty class (operand width
// ZW = max(SAMPLE_BITS+COUNT_BITS, 40)), steps past the other classes, then runs the update
// lap over all CLASSES cells and emits; a negative current_class skips the search.
// Reset (rst, synchronous) clears counts, sums, deltas and tally; config 16/4.
// ----------------------------------------------------------------------------
module kmeans_reassign_pass_unit #(
  parameter int CLASSES     = 16,
  parameter int BANDS       = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [krp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [krp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [3:0]                          class_index,
  input  logic [1:0]                          band_index,
  input  logic [39:0]                         load_value,
  input  logic [15:0]                         sample_0,
  input  logic [15:0]                         sample_1,
  input  logic [15:0]                         sample_2,
  input  logic [15:0]                         sample_3,
  input  logic signed [4:0]                   current_class,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [4:0]                   new_class,
  output logic                                moved,
  output logic [23:0]                         pass_changes,
  output logic                                pass_end
);

  localparam int SUMW = krp_pkg::SUM_BITS;
  localparam int SDW  = krp_pkg::SDELTA_BITS;
  localparam int TW   = krp_pkg::TALLY_BITS;
  localparam int KW   = $clog2(CLASSES);
  localparam int NCW  = $clog2(CLASSES + 1);
  localparam int BCW  = $clog2(BANDS + 1);
  localparam int PW   = SAMPLE_BITS + COUNT_BITS;
  localparam int ZW   = (PW > SUMW) ? PW : SUMW;
  localparam int NW   = 2 * ZW + 3;
  localparam int N2W  = 2 * COUNT_BITS;
  localparam int XW   = NW + N2W;

  krp_pkg::state_t state, state_next;

  logic [4:0] cfg_classes;
  logic [2:0] cfg_bands;
  logic [NCW-1:0] nc;
  logic [BCW-1:0] nb;

  logic [KW-1:0]  k;
  logic [BCW-1:0] bidx;
  logic [BANDS-1:0][SAMPLE_BITS-1:0] x;
  logic [3:0]     cur_cls;
  logic           last_r;
  logic           found;
  logic [KW-1:0]  best;
  logic [NW-1:0]  best_num;
  logic [N2W-1:0] best_n2;
  logic [NW-1:0]  num;
  logic [PW-1:0]  p_reg;
  logic [N2W-1:0] n2_reg;
  logic [TW-1:0]  tally;
  logic           moved_r;
  logic [4:0]     res_class;
  logic           res_moved;
  logic [TW-1:0]  res_changes;
  logic           res_end;

  logic accept;
  logic emit_load;
  logic mv;
  logic [TW-1:0] tally_inc;
  logic [3:0][15:0] samples;

  krp_pkg::cell_ctl_t ctl;
  logic sq_start, x_start;
  logic sq_done, xl_done, xr_done;
  logic [2*ZW-1:0] sq_prod;
  logic [XW-1:0]   xl_prod, xr_prod;
  logic [ZW-1:0]   z, p_ext, s_ext;
  logic [SUMW-1:0] hs;
  logic [SAMPLE_BITS-1:0] hx;

  // chain storage
  logic [CLASSES-1:0][COUNT_BITS-1:0]           c_count;
  logic [CLASSES-1:0][BANDS-1:0][SUMW-1:0]      c_sum;
  logic [CLASSES-1:0][COUNT_BITS:0]             c_cd;
  logic [CLASSES-1:0][BANDS-1:0][SDW-1:0]       c_sd;

  logic [COUNT_BITS-1:0]           t_count, u_count;
  logic [BANDS-1:0][SUMW-1:0]      t_sum, u_sum;
  logic [COUNT_BITS:0]             t_cd, u_cd;
  logic [BANDS-1:0][SDW-1:0]       t_sd, u_sd;
  logic is_best, is_cur;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign samples   = {sample_3, sample_2, sample_1, sample_0};

  always_comb begin
    if (cfg_classes == 5'd0) nc = NCW'(1);
    else if (32'(cfg_classes) > CLASSES) nc = NCW'(CLASSES);
    else nc = NCW'(cfg_classes);
    if (cfg_bands == 3'd0) nb = BCW'(1);
    else if (32'(cfg_bands) > BANDS) nb = BCW'(BANDS);
    else nb = BCW'(cfg_bands);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_classes <= 5'd16;
      cfg_bands   <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == krp_pkg::REG_ACTIVE_CLASSES) cfg_classes <= cfg_data;
      else if (cfg_index == krp_pkg::REG_ACTIVE_BANDS) cfg_bands <= cfg_data[2:0];
    end
  end

  // head band selection
  always_comb begin
    hs = '0;
    hx = '0;
    for (int j = 0; j < BANDS; j++) begin
      if (bidx == BCW'(j)) begin
        hs = c_sum[0][j];
        hx = x[j];
      end
    end
    p_ext = ZW'(p_reg);
    s_ext = ZW'(hs);
    z = (p_ext >= s_ext) ? p_ext - s_ext : s_ext - p_ext;
  end

  assign mv        = (32'(cur_cls) != 32'(best));
  assign tally_inc = (mv && tally != krp_pkg::TALLY_MAX) ? tally + TW'(1) : tally;

  // head update for the apply lap
  always_comb begin
    is_best = moved_r && (k == best);
    is_cur  = moved_r && (32'(k) == 32'(cur_cls)) && (32'(cur_cls) < 32'(nc));
    u_count = c_count[0];
    u_sum   = c_sum[0];
    u_cd    = c_cd[0];
    u_sd    = c_sd[0];
    if (is_best) u_cd = u_cd + (COUNT_BITS+1)'(1);
    if (is_cur)  u_cd = u_cd - (COUNT_BITS+1)'(1);
    for (int j = 0; j < BANDS; j++) begin
      if (32'(j) < 32'(nb)) begin
        if (is_best) u_sd[j] = u_sd[j] + SDW'(x[j]);
        if (is_cur)  u_sd[j] = u_sd[j] - SDW'(x[j]);
      end
    end
    if (last_r) begin
      if (32'(k) < 32'(nc)) begin
        u_count = u_count + u_cd[COUNT_BITS-1:0];
        for (int j = 0; j < BANDS; j++) begin
          if (32'(j) < 32'(nb)) u_sum[j] = u_sum[j] + u_sd[j][SUMW-1:0];
        end
      end
      u_cd = '0;
      u_sd = '0;
    end
  end

  always_comb begin
    if (state == krp_pkg::ST_APPLY) begin
      t_count = u_count;
      t_sum   = u_sum;
      t_cd    = u_cd;
      t_sd    = u_sd;
    end else begin
      t_count = c_count[0];
      t_sum   = c_sum[0];
      t_cd    = c_cd[0];
      t_sd    = c_sd[0];
    end
  end

  for (genvar i = 0; i < CLASSES; i++) begin : g_cell
    if (i == CLASSES - 1) begin : g_tail
      krp_cell #(.BANDS(BANDS), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk, .rst, .ctl,
        .sel(32'(class_index) == i), .load_value,
        .nxt_count(t_count), .nxt_sum(t_sum), .nxt_cd(t_cd), .nxt_sd(t_sd),
        .count(c_count[i]), .sum(c_sum[i]), .cd(c_cd[i]), .sd(c_sd[i])
      );
    end else begin : g_body
      krp_cell #(.BANDS(BANDS), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk, .rst, .ctl,
        .sel(32'(class_index) == i), .load_value,
        .nxt_count(c_count[i+1]), .nxt_sum(c_sum[i+1]), .nxt_cd(c_cd[i+1]),
        .nxt_sd(c_sd[i+1]),
        .count(c_count[i]), .sum(c_sum[i]), .cd(c_cd[i]), .sd(c_sd[i])
      );
    end
  end

  krp_sermul #(.AW(ZW), .BW(ZW)) u_sq (
    .clk, .rst, .start(sq_start), .a(z), .b(z), .done(sq_done), .prod(sq_prod)
  );
  krp_sermul #(.AW(NW), .BW(N2W)) u_xl (
    .clk, .rst, .start(x_start), .a(num), .b(best_n2), .done(xl_done), .prod(xl_prod)
  );
  krp_sermul #(.AW(NW), .BW(N2W)) u_xr (
    .clk, .rst, .start(x_start), .a(best_num), .b(n2_reg), .done(xr_done),
    .prod(xr_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      krp_pkg::ST_IDLE: begin
        if (accept) begin
          case (krp_pkg::op_t'(opcode))
            krp_pkg::OP_ABORT: state_next = krp_pkg::ST_EMIT;
            krp_pkg::OP_POINT:
              state_next = current_class[4] ? krp_pkg::ST_APPLY : krp_pkg::ST_CLASS;
            default: state_next = krp_pkg::ST_IDLE;
          endcase
        end
      end
      krp_pkg::ST_CLASS: begin
        if (32'(k) < 32'(nc) && c_count[0] != '0) state_next = krp_pkg::ST_PROD;
        else state_next = krp_pkg::ST_NEXT;
      end
      krp_pkg::ST_PROD:  state_next = krp_pkg::ST_SQ_GO;
      krp_pkg::ST_SQ_GO: state_next = krp_pkg::ST_SQ_WAIT;
      krp_pkg::ST_SQ_WAIT: begin
        if (sq_done) begin
          state_next = (bidx + BCW'(1) == nb) ? krp_pkg::ST_X_GO : krp_pkg::ST_PROD;
        end
      end
      krp_pkg::ST_X_GO: state_next = krp_pkg::ST_X_WAIT;
      krp_pkg::ST_X_WAIT: begin
        if (xl_done) state_next = krp_pkg::ST_NEXT;
      end
      krp_pkg::ST_NEXT: begin
        state_next = (k == KW'(CLASSES - 1)) ? krp_pkg::ST_APPLY : krp_pkg::ST_CLASS;
      end
      krp_pkg::ST_APPLY: begin
        if (k == KW'(CLASSES - 1)) state_next = krp_pkg::ST_EMIT;
      end
      krp_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = krp_pkg::ST_IDLE;
      end
      default: state_next = krp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall     = (state != krp_pkg::ST_IDLE);
    ctl          = '0;
    ctl.band     = {1'b0, band_index};
    sq_start     = 1'b0;
    x_start      = 1'b0;
    emit_load    = 1'b0;
    case (state)
      krp_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.wr_count = (krp_pkg::op_t'(opcode) == krp_pkg::OP_LOAD_COUNT) &&
                         (32'(class_index) < CLASSES);
          ctl.wr_sum   = (krp_pkg::op_t'(opcode) == krp_pkg::OP_LOAD_SUM) &&
                         (32'(class_index) < CLASSES) && (32'(band_index) < BANDS);
          ctl.clr      = (krp_pkg::op_t'(opcode) == krp_pkg::OP_ABORT);
        end
      end
      krp_pkg::ST_SQ_GO: sq_start  = 1'b1;
      krp_pkg::ST_X_GO:  x_start   = 1'b1;
      krp_pkg::ST_NEXT:  ctl.shift = 1'b1;
      krp_pkg::ST_APPLY: ctl.shift = 1'b1;
      krp_pkg::ST_EMIT:  emit_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= krp_pkg::ST_IDLE;
      tally     <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      state <= state_next;
      if (emit_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        krp_pkg::ST_IDLE: begin
          if (accept && krp_pkg::op_t'(opcode) == krp_pkg::OP_ABORT) begin
            tally <= '0;
          end
        end
        krp_pkg::ST_NEXT: begin
          if (k == KW'(CLASSES - 1)) begin
            k     <= '0;
            tally <= tally_inc;
          end else begin
            k <= k + KW'(1);
          end
        end
        krp_pkg::ST_APPLY: begin
          if (k == KW'(CLASSES - 1)) begin
            k <= '0;
            if (last_r) tally <= '0;
          end else begin
            k <= k + KW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      krp_pkg::ST_IDLE: begin
        if (accept) begin
          for (int j = 0; j < BANDS; j++) begin
            x[j] <= (j < 4) ? samples[j][SAMPLE_BITS-1:0] : '0;
          end
          cur_cls  <= current_class[3:0];
          last_r   <= last_point;
          found    <= 1'b0;
          best     <= '0;
          best_num <= '0;
          best_n2  <= '0;
          moved_r  <= 1'b0;
          if (krp_pkg::op_t'(opcode) == krp_pkg::OP_ABORT) begin
            res_class   <= '0;
            res_moved   <= 1'b0;
            res_changes <= '0;
            res_end     <= 1'b1;
          end else begin
            res_class   <= 5'h1F;
            res_moved   <= 1'b0;
            res_changes <= tally;
            res_end     <= last_point;
          end
        end
      end
      krp_pkg::ST_CLASS: begin
        num  <= '0;
        bidx <= '0;
      end
      krp_pkg::ST_PROD: p_reg <= PW'(hx) * PW'(c_count[0]);
      krp_pkg::ST_SQ_WAIT: begin
        if (sq_done) begin
          num    <= num + NW'(sq_prod);
          bidx   <= bidx + BCW'(1);
          n2_reg <= N2W'(c_count[0]) * N2W'(c_count[0]);
        end
      end
      krp_pkg::ST_X_WAIT: begin
        if (xl_done && xr_done && (!found || xl_prod < xr_prod)) begin
          found    <= 1'b1;
          best     <= k;
          best_num <= num;
          best_n2  <= n2_reg;
        end
      end
      krp_pkg::ST_NEXT: begin
        if (k == KW'(CLASSES - 1)) begin
          moved_r     <= mv;
          res_class   <= 5'(best);
          res_moved   <= mv;
          res_changes <= tally_inc;
        end
      end
      default: ;
    endcase
    if (emit_load) begin
      new_class    <= res_class;
      moved        <= res_moved;
      pass_changes <= res_changes;
      pass_end     <= res_end;
    end
  end

endmodule

>>> sv/krp_check.sv
// ----------------------------------------------------------------------------
// krp_check: port-level checks for the reassignment pass unit
// Watches results and the output handshake; attached by bind.
// ----------------------------------------------------------------------------
module krp_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [krp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input logic [krp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        opcode,
  input logic [3:0]                        class_index,
  input logic [1:0]                        band_index,
  input logic [39:0]                       load_value,
  input logic [15:0]                       sample_0,
  input logic [15:0]                       sample_1,
  input logic [15:0]                       sample_2,
  input logic [15:0]                       sample_3,
  input logic signed [4:0]                 current_class,
  input logic                              last_point,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [4:0]                 new_class,
  input logic                              moved,
  input logic [23:0]                       pass_changes,
  input logic                              pass_end
);

  // an ignored point never moves
  a_ignored_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_class == -5'sd1 |-> !moved)
    else $error("ignored point reported as moved");

  // a move is always counted
  a_move_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> pass_changes != 24'd0)
    else $error("move reported with zero change tally");

  // abort-shaped result (pass end, zero tally, class not -1): consequent only repeats !moved
  a_abort_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && pass_end && !moved && pass_changes == 24'd0 && new_class != -5'sd1
      |-> !moved)
    else $error("abort result not clean");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_class) && $stable(pass_changes))
    else $error("stalled result changed");

endmodule

bind kmeans_reassign_pass_unit krp_check u_krp_check (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for kmeans_reassign_pass_unit
// Streams load, point and abort requests under random sender and receiver
// idling, predicts every result with an exact-integer nearest-mean search
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCLS = 16;
  localparam int NBND = 4;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    krp_pkg::op_t      op;
    logic [3:0]        ci;
    logic [1:0]        bi;
    logic [39:0]       lv;
    logic [3:0][15:0]  smp;
    logic signed [4:0] cur;
    logic              last;
  } req_t;

  typedef struct packed {
    logic signed [4:0] cls;
    logic              mv;
    logic [23:0]       chg;
    logic              pend;
  } res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [krp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [krp_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic [3:0] class_index;
  logic [1:0] band_index;
  logic [39:0] load_value;
  logic [15:0] sample_0, sample_1, sample_2, sample_3;
  logic signed [4:0] current_class;
  logic last_point;
  logic out_valid, out_stall;
  logic signed [4:0] new_class;
  logic moved;
  logic [23:0] pass_changes;
  logic pass_end;

  kmeans_reassign_pass_unit u_top (.*);

  // predictor state
  logic [23:0] cnt [NCLS];
  logic [39:0] bsum [NCLS*NBND];
  logic [24:0] cnt_dlt [NCLS];
  logic [40:0] sum_dlt [NCLS*NBND];
  logic [23:0] tally;
  logic [4:0]  reg_classes;
  logic [2:0]  reg_bands;

  res_t exp_results [$];
  int   send_idle_pct, recv_stall_pct;
  int   n_sent;
  int   errors = 0;
  int   quiet_cycles = 0;

  initial forever #6 clk = ~clk;

  function automatic int eff_classes();
    if (reg_classes == 0) return 1;
    return (reg_classes > NCLS) ? NCLS : reg_classes;
  endfunction

  function automatic int eff_bands();
    if (reg_bands == 0) return 1;
    return (reg_bands > NBND) ? NBND : reg_bands;
  endfunction

  task automatic clear_pass();
    for (int i = 0; i < NCLS; i++) cnt_dlt[i] = '0;
    for (int i = 0; i < NCLS*NBND; i++) sum_dlt[i] = '0;
    tally = '0;
  endtask

  task automatic predict_request(input req_t r);
    int nc, nb, best;
    bit found;
    logic [191:0] num, bnum, bn2, n2, z;
    logic [63:0] p, s, n;
    res_t e;
    nc = eff_classes();
    nb = eff_bands();
    e = '0;
    case (r.op)
      krp_pkg::OP_LOAD_COUNT: begin
        cnt[r.ci] = r.lv[23:0];
        return;
      end
      krp_pkg::OP_LOAD_SUM: begin
        bsum[r.ci*NBND + r.bi] = r.lv;
        return;
      end
      krp_pkg::OP_ABORT: begin
        clear_pass();
        e.pend = 1'b1;
        exp_results.push_back(e);
        return;
      end
      default: begin
        if (r.cur[4]) begin
          e.cls = -5'sd1;
        end else begin
          found = 0;
          best = 0;
          bnum = '0;
          bn2 = '0;
          for (int c = 0; c < nc; c++) begin
            n = cnt[c];
            if (n == 0) continue;
            num = '0;
            for (int b = 0; b < nb; b++) begin
              p = r.smp[b] * n;
              s = bsum[c*NBND + b];
              z = (p >= s) ? p - s : s - p;
              num = num + z * z;
            end
            n2 = n * n;
            if (!found || (num * bn2 < bnum * n2)) begin
              best = c;
              bnum = num;
              bn2 = n2;
              found = 1;
            end
          end
          if (r.cur[3:0] != best) begin
            e.mv = 1'b1;
            if (tally != krp_pkg::TALLY_MAX) tally++;
            cnt_dlt[best] = cnt_dlt[best] + 25'd1;
            for (int b = 0; b < nb; b++)
              sum_dlt[best*NBND + b] = sum_dlt[best*NBND + b] + r.smp[b];
            if (r.cur < nc) begin
              cnt_dlt[r.cur[3:0]] = cnt_dlt[r.cur[3:0]] - 25'd1;
              for (int b = 0; b < nb; b++)
                sum_dlt[r.cur[3:0]*NBND + b] = sum_dlt[r.cur[3:0]*NBND + b] - r.smp[b];
            end
          end
          e.cls = 5'(best);
        end
        e.chg = tally;
        e.pend = r.last;
        exp_results.push_back(e);
        if (r.last) begin
          for (int c = 0; c < nc; c++) begin
            cnt[c] = cnt[c] + cnt_dlt[c][23:0];
            for (int b = 0; b < nb; b++)
              bsum[c*NBND + b] = bsum[c*NBND + b] + sum_dlt[c*NBND + b][39:0];
          end
          clear_pass();
        end
      end
    endcase
  endtask

  // Present one request, hold it until accepted, then update the predictor.
  task automatic send(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= r.op;
    class_index   <= r.ci;
    band_index    <= r.bi;
    load_value    <= r.lv;
    sample_0      <= r.smp[0];
    sample_1      <= r.smp[1];
    sample_2      <= r.smp[2];
    sample_3      <= r.smp[3];
    current_class <= r.cur;
    last_point    <= r.last;
    do @(posedge clk); while (in_stall);
    predict_request(r);
    n_sent++;
  endtask

  function automatic req_t load_req(krp_pkg::op_t op, int c, int b, logic [39:0] v);
    req_t r;
    r = '0;
    r.op = op;
    r.ci = 4'(c);
    r.bi = 2'(b);
    r.lv = v;
    r.smp = {$urandom, $urandom};
    r.cur = 5'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  function automatic req_t point_req(logic [63:0] smp, logic signed [4:0] cur, bit last);
    req_t r;
    r = '0;
    r.op = krp_pkg::OP_POINT;
    r.ci = 4'($urandom);
    r.bi = 2'($urandom);
    r.lv = 40'({$urandom, $urandom});
    r.smp = smp;
    r.cur = cur;
    r.last = last;
    return r;
  endfunction

  // Drop valid, let every result drain, then give loads time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Hold one register write until taken; the caller drops valid.
  task automatic write_reg(input logic [krp_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [krp_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == krp_pkg::REG_ACTIVE_CLASSES) reg_classes = val;
    else if (idx == krp_pkg::REG_ACTIVE_BANDS) reg_bands = val[2:0];
  endtask

  task automatic set_config(input logic [4:0] cls, input logic [4:0] bnd);
    drain();
    write_reg(krp_pkg::REG_ACTIVE_CLASSES, cls);
    write_reg(krp_pkg::REG_ACTIVE_BANDS, bnd);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [63:0] mid;
    mid = {4{16'd100}};
    // all classes empty: class 0 wins
    send(point_req({4{16'hFFFF}}, 5'sd3, 1'b0));
    send(point_req('0, -5'sd1, 1'b0));
    send(load_req(krp_pkg::OP_ABORT, 0, 0, '0));
    // two identical classes tie: lowest index wins
    send(load_req(krp_pkg::OP_LOAD_COUNT, 0, 0, 40'd4));
    send(load_req(krp_pkg::OP_LOAD_COUNT, 1, 0, 40'd4));
    for (int b = 0; b < 4; b++) begin
      send(load_req(krp_pkg::OP_LOAD_SUM, 0, b, 40'd400));
      send(load_req(krp_pkg::OP_LOAD_SUM, 1, b, 40'd400));
    end
    send(load_req(krp_pkg::OP_LOAD_COUNT, 15, 0, 40'hFF_FFFF_FFFF));
    send(load_req(krp_pkg::OP_LOAD_SUM, 15, 3, 40'hFF_FFFF_FFFF));
    send(point_req(mid, 5'sd5, 1'b0));
    send(point_req({4{16'hFFFF}}, 5'sd15, 1'b0));
    // ignored last point still commits
    send(point_req(mid, -5'sd16, 1'b1));
    // old class outside the active set is not debited
    set_config(5'd2, 5'd1);
    send(point_req({4{16'hFFFF}}, 5'sd15, 1'b1));
    send(point_req('0, 5'sd1, 1'b0));
    send(load_req(krp_pkg::OP_ABORT, 0, 0, '0));
  endtask

  // One pass: load the active classes, stream points, then close or abort.
  task automatic run_pass(input int npts);
    int nc, nb, k;
    logic [63:0] smp;
    logic [63:0] n;
    logic signed [4:0] cur;
    nc = eff_classes();
    nb = eff_bands();
    for (int c = 0; c < nc; c++) begin
      if ($urandom_range(9) < 2) continue;
      k = $urandom_range(19);
      n = (k == 0) ? 64'd0 : (k == 1) ? {$urandom, $urandom} :
          64'($urandom_range(1, 60));
      send(load_req(krp_pkg::OP_LOAD_COUNT, c, 0, n[39:0]));
      for (int b = 0; b < nb; b++)
        send(load_req(krp_pkg::OP_LOAD_SUM, c, b, ($urandom_range(9) == 0) ?
             40'({$urandom, $urandom}) : 40'(n[23:0] * $urandom_range(0, 65535))));
    end
    if ($urandom_range(9) == 0)
      send(load_req(krp_pkg::op_t'($urandom_range(1)), $urandom, $urandom,
                    40'({$urandom, $urandom})));
    for (int i = 0; i < npts; i++) begin
      k = $urandom_range(9);
      smp = {$urandom, $urandom};
      if (k == 0) smp = '0;
      else if (k == 1) smp = '1;
      k = $urandom_range(19);
      cur = (k < 16) ? 5'($urandom_range(nc - 1)) : (k < 18) ? -5'sd1 : 5'($urandom);
      if (i == npts - 1 && $urandom_range(7) == 0)
        send(load_req(krp_pkg::OP_ABORT, 0, 0, '0));
      else
        send(point_req(smp, cur, i == npts - 1));
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int quota);
    int stop_at, k;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = n_sent + quota;
    // widest setting first, with few points since every class is searched
    set_config(5'd16, 5'd4);
    run_pass(3);
    set_config(5'd31, 5'd7);
    run_pass(2);
    while (n_sent < stop_at) begin
      k = $urandom_range(9);
      set_config((k == 0) ? 5'd0 : (k == 1) ? 5'd1 : 5'($urandom_range(2, 4)),
                 (k == 2) ? 5'd0 : 5'($urandom_range(1, 2)));
      run_pass($urandom_range(2, 10));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        $error("unexpected result: new_class=%0d", new_class);
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (new_class !== e.cls) begin
          $error("new_class exp %0d got %0d", e.cls, new_class); errors++;
        end
        if (moved !== e.mv) begin
          $error("moved exp %0d got %0d", e.mv, moved); errors++;
        end
        if (pass_changes !== e.chg) begin
          $error("pass_changes exp %0d got %0d", e.chg, pass_changes); errors++;
        end
        if (pass_end !== e.pend) begin
          $error("pass_end exp %0d got %0d", e.pend, pass_end); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= '0;
    class_index <= '0;
    band_index <= '0;
    load_value <= '0;
    sample_0 <= '0;
    sample_1 <= '0;
    sample_2 <= '0;
    sample_3 <= '0;
    current_class <= '0;
    last_point <= 1'b0;
    n_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NCLS; i++) cnt[i] = '0;
    for (int i = 0; i < NCLS*NBND; i++) bsum[i] = '0;
    clear_pass();
    reg_classes = 5'd16;
    reg_bands = 3'd4;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(7, 61, 340);
    test_random_phase(61, 7, 340);
    test_random_phase(0, 0, 340);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && exp_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
sv/krp_pkg.sv
sv/krp_cell.sv
sv/krp_sermul.sv
sv/kmeans_reassign_pass_unit.sv
sv/krp_check.sv
verif/tb.sv
